@@ rtl/kfsl_pkg.sv @@
// Shared constants, codes and types for the keyframe segment locator.
`timescale 1ns / 1ps
package kfsl_pkg;

    localparam int KEYS_MAX  = 256;
    localparam int ADDR_W    = $clog2(KEYS_MAX);
    localparam int IDX_W     = ADDR_W + 1;
    localparam int KEY_W     = 17;
    localparam int THR_W     = KEY_W + 1;
    localparam int EPS_W     = 13;
    localparam int PROD_W    = KEY_W + ADDR_W;
    localparam int DIV_STEPS = KEY_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [KEY_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [KEY_W-1:0] FRAC_LO = 17'd66;
    localparam logic [KEY_W-1:0] FRAC_HI = 17'd65470;

    localparam logic [1:0] REG_NUM_KEYS = 2'd0;
    localparam logic [1:0] REG_UNIFORM  = 2'd1;
    localparam logic [1:0] REG_EPSILON  = 2'd2;

    localparam logic [2:0] RES_UNI  = 3'd0;
    localparam logic [2:0] RES_LAST = 3'd1;
    localparam logic [2:0] RES_LO   = 3'd2;
    localparam logic [2:0] RES_HI   = 3'd3;
    localparam logic [2:0] RES_QUO  = 3'd4;

    typedef struct packed {
        logic [IDX_W-1:0] num_keys;
        logic             uniform_mode;
        logic [EPS_W-1:0] epsilon;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       key_wr;
        logic       mul;
        logic       rd_en;
        logic       rd_prev;
        logic       idx_inc;
        logic       restart;
        logic       fix;
        logic       khi_ld;
        logic       diff_ld;
        logic       div_init;
        logic       div_step;
        logic       emit;
        logic [2:0] res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_lt_lim;
        logic key_gt_thr;
        logic idx_zero;
        logic pass;
        logic fix_ge_n;
        logic den_zero;
        logic sign_mis;
        logic quo_big;
        logic div_last;
    } t_dp_sts;

endpackage

@@ rtl/kfsl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kfsl_ram #(
    parameter int WIDTH  = 17,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/kfsl_regs.sv @@
// APB configuration registers of the keyframe segment locator.
`timescale 1ns / 1ps
module kfsl_regs import kfsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [IDX_W-1:0] r_num_keys;
    logic             r_uniform;
    logic [EPS_W-1:0] r_epsilon;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_keys <= IDX_W'(2);
            r_uniform  <= 1'b1;
            r_epsilon  <= EPS_W'(7);
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_NUM_KEYS: r_num_keys <= pwdata[IDX_W-1:0];
                REG_UNIFORM:  r_uniform  <= pwdata[0];
                REG_EPSILON:  r_epsilon  <= pwdata[EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_KEYS: prdata = PDATA_W'(r_num_keys);
            REG_UNIFORM:  prdata = PDATA_W'(r_uniform);
            REG_EPSILON:  prdata = PDATA_W'(r_epsilon);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.num_keys     = r_num_keys;
    assign o_cfg.uniform_mode = r_uniform;
    assign o_cfg.epsilon      = r_epsilon;

endmodule

@@ rtl/kfsl_ctrl.sv @@
// Sequencing state machine of the keyframe segment locator.
`timescale 1ns / 1ps
module kfsl_ctrl import kfsl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_action,
    input  t_cfg    i_cfg,
    input  t_dp_sts i_sts,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UMUL  = 4'd1;
    localparam logic [3:0] S_UOUT  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SCMP  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_CCMP  = 4'd6;
    localparam logic [3:0] S_FIX   = 4'd7;
    localparam logic [3:0] S_RDHI  = 4'd8;
    localparam logic [3:0] S_RDLO  = 4'd9;
    localparam logic [3:0] S_DIFF  = 4'd10;
    localparam logic [3:0] S_DSET  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_CLAMP = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.key_wr = w_accept && !i_action;
                o_cmd.load   = w_accept && i_action;
                if (w_accept && i_action) begin
                    n_state = i_cfg.uniform_mode ? S_UMUL : S_SCAN;
                end
            end
            S_UMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UOUT;
            end
            S_UOUT: begin
                o_cmd.emit    = 1'b1;
                o_cmd.res_sel = RES_UNI;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.idx_lt_lim) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCMP;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_SCMP: begin
                if (i_sts.key_gt_thr) begin
                    n_state = S_CHK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_CHK: begin
                if (!i_sts.pass && !i_sts.idx_zero) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CCMP;
                end else begin
                    n_state = S_FIX;
                end
            end
            S_CCMP: begin
                if (i_sts.key_gt_thr) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_SCAN;
                end else begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                if (i_sts.fix_ge_n) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_LAST;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_RDHI;
                end
            end
            S_RDHI: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RDLO;
            end
            S_RDLO: begin
                o_cmd.khi_ld  = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_prev = 1'b1;
                n_state       = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_ld = 1'b1;
                n_state       = S_DSET;
            end
            S_DSET: begin
                if (i_sts.den_zero || (!i_sts.sign_mis && i_sts.quo_big)) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_HI;
                    n_state       = S_IDLE;
                end else if (i_sts.sign_mis) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_LO;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.emit    = 1'b1;
                o_cmd.res_sel = RES_QUO;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/kfsl_dp.sv @@
// Datapath: key table, search index, multiplier, serial divider and result beat.
`timescale 1ns / 1ps
module kfsl_dp import kfsl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_dp_cmd           i_cmd,
    input  logic [ADDR_W-1:0] i_key_index,
    input  logic [KEY_W-1:0]  i_key_time,
    input  logic [KEY_W-1:0]  i_position,
    output t_dp_sts           o_sts,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_segment,
    output logic [KEY_W-1:0]  o_fraction
);

    logic [KEY_W-1:0]  r_pos;
    logic [THR_W-1:0]  r_thr;
    logic [IDX_W-1:0]  r_n;
    logic [IDX_W-1:0]  r_start;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_lim;
    logic [IDX_W-1:0]  r_last;
    logic              r_pass;
    logic [PROD_W-1:0] r_prod;
    logic [KEY_W-1:0]  r_khi;
    logic [THR_W-1:0]  r_num;
    logic [THR_W-1:0]  r_den;
    logic [KEY_W-1:0]  r_ad;
    logic [KEY_W-1:0]  r_rem;
    logic              r_dbit;
    logic [KEY_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_valid;
    logic [ADDR_W-1:0] r_seg;
    logic [KEY_W-1:0]  r_frac;

    logic [IDX_W-1:0]  w_n;
    logic [IDX_W-1:0]  w_start;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [KEY_W-1:0]  w_rd_data;
    logic [IDX_W-1:0]  w_idx_fix;
    logic [IDX_W-1:0]  w_nm1;
    logic [IDX_W-1:0]  w_nm2;
    logic [IDX_W-1:0]  w_idx_m1;
    logic [THR_W-1:0]  w_an_full;
    logic [THR_W-1:0]  w_ad_full;
    logic [KEY_W-1:0]  w_an;
    logic [KEY_W-1:0]  w_ad;
    logic [THR_W-1:0]  w_trial;
    logic [THR_W-1:0]  w_sub;
    logic              w_ge;
    logic [IDX_W-1:0]  w_ip;
    logic [KEY_W-1:0]  w_hi_lim;
    logic [KEY_W-1:0]  w_f;
    logic [ADDR_W-1:0] n_seg;
    logic [KEY_W-1:0]  n_frac;

    always_comb begin
        if (i_cfg.num_keys < IDX_W'(2)) begin
            w_n = IDX_W'(2);
        end else if (i_cfg.num_keys > IDX_W'(KEYS_MAX)) begin
            w_n = IDX_W'(KEYS_MAX);
        end else begin
            w_n = i_cfg.num_keys;
        end
    end

    assign w_start   = (r_last < w_n) ? r_last : w_n;
    assign w_idx_m1  = r_idx - IDX_W'(1);
    assign w_rd_idx  = i_cmd.rd_prev ? w_idx_m1 : r_idx;
    assign w_idx_fix = (r_idx == '0) ? IDX_W'(1) : r_idx;
    assign w_nm1     = r_n - IDX_W'(1);
    assign w_nm2     = r_n - IDX_W'(2);

    kfsl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEYS_MAX)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.key_wr),
        .i_wr_addr (i_key_index),
        .i_wr_data (i_key_time),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_an_full = r_num[THR_W-1] ? (THR_W'(0) - r_num) : r_num;
    assign w_ad_full = r_den[THR_W-1] ? (THR_W'(0) - r_den) : r_den;
    assign w_an      = w_an_full[KEY_W-1:0];
    assign w_ad      = w_ad_full[KEY_W-1:0];

    assign w_trial = {r_rem, r_dbit};
    assign w_ge    = (w_trial >= {1'b0, r_ad});
    assign w_sub   = w_trial - {1'b0, r_ad};

    assign o_sts.idx_lt_lim = (r_idx < r_lim);
    assign o_sts.key_gt_thr = ({1'b0, w_rd_data} > r_thr);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.pass       = r_pass;
    assign o_sts.fix_ge_n   = (w_idx_fix >= r_n);
    assign o_sts.den_zero   = (r_den == '0);
    assign o_sts.sign_mis   = (r_num[THR_W-1] != r_den[THR_W-1]) && (r_num != '0);
    assign o_sts.quo_big    = ({1'b0, w_an[KEY_W-1:1]} >= w_ad);
    assign o_sts.div_last   = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_pass  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_pass <= 1'b0;
            end else if (i_cmd.restart) begin
                r_pass <= 1'b1;
            end
            if (i_cmd.fix) begin
                r_last <= w_idx_fix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos   <= i_position;
            r_thr   <= {1'b0, i_position} + THR_W'(i_cfg.epsilon);
            r_n     <= w_n;
            r_start <= w_start;
            r_idx   <= w_start;
            r_lim   <= w_n;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end else if (i_cmd.restart) begin
            r_idx <= '0;
            r_lim <= r_start;
        end else if (i_cmd.fix) begin
            r_idx <= w_idx_fix;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_pos) * PROD_W'(w_nm1[ADDR_W-1:0]);
        end
        if (i_cmd.khi_ld) begin
            r_khi <= w_rd_data;
        end
        if (i_cmd.diff_ld) begin
            r_num <= {1'b0, r_khi} - {1'b0, r_pos};
            r_den <= {1'b0, r_khi} - {1'b0, w_rd_data};
        end
        if (i_cmd.div_init) begin
            r_ad   <= w_ad;
            r_rem  <= {1'b0, w_an[KEY_W-1:1]};
            r_dbit <= w_an[0];
            r_q    <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_sub[KEY_W-1:0] : w_trial[KEY_W-1:0];
            r_dbit <= 1'b0;
            r_q    <= {r_q[KEY_W-2:0], w_ge};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_seg  <= n_seg;
            r_frac <= n_frac;
        end
    end

    assign w_ip     = r_prod[PROD_W-1:16];
    assign w_hi_lim = ONE_Q16 - KEY_W'(i_cfg.epsilon);

    always_comb begin
        if (r_q < KEY_W'(i_cfg.epsilon)) begin
            w_f = FRAC_LO;
        end else if (r_q > w_hi_lim) begin
            w_f = FRAC_HI;
        end else begin
            w_f = r_q;
        end
    end

    always_comb begin
        n_seg  = w_idx_m1[ADDR_W-1:0];
        n_frac = ONE_Q16;
        unique case (i_cmd.res_sel)
            RES_UNI: begin
                if (w_ip >= w_nm1) begin
                    n_seg  = w_nm2[ADDR_W-1:0];
                    n_frac = ONE_Q16;
                end else begin
                    n_seg  = w_ip[ADDR_W-1:0];
                    n_frac = {1'b0, r_prod[15:0]};
                end
            end
            RES_LAST: begin
                n_seg  = w_nm2[ADDR_W-1:0];
                n_frac = ONE_Q16 - FRAC_LO;
            end
            RES_LO:  n_frac = ONE_Q16 - FRAC_LO;
            RES_HI:  n_frac = ONE_Q16 - FRAC_HI;
            RES_QUO: n_frac = ONE_Q16 - w_f;
            default: begin
            end
        endcase
    end

    assign o_valid    = r_valid;
    assign o_segment  = r_seg;
    assign o_fraction = r_frac;

endmodule

@@ rtl/keyframe_segment_locator.sv @@
// Top level of the keyframe segment locator.
`timescale 1ns / 1ps
// Command channel: an item is taken at a clock edge with start high and busy low.
// i_action = 0 writes i_key_time into key table entry i_key_index; it yields no
// result and busy stays low. i_action = 1 locates i_position.
// Result channel: o_valid marks a beat of o_segment and o_fraction for exactly one
// cycle; the receiver has no way to stall, so the beat is taken as it stands.
// Uniform mode: S_UMUL forms one 17x8 multiply, S_UOUT emits the figure; o_valid
// rises at the edge at which busy drops, and the next command may follow at once.
// Table mode: the walk reads the key RAM one entry at a time from the remembered
// index and may rescan from entry 0; the 17-step restoring divider then forms the
// fraction. A position past the last key skips the divide.
// Configuration goes through the APB port (num_keys at 0x0, uniform_mode at 0x4,
// epsilon at 0x8); pready is always high. The user must configure it only while the
// block is idle; the block itself does not enforce this.
// Reset (synchronous, active low) restores num_keys = 2, uniform_mode = 1,
// epsilon = 7, clears the remembered search index and drops any query in flight.
// The key table is not cleared and must be written before table-mode use.
module keyframe_segment_locator import kfsl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_key_index,
    input  logic [KEY_W-1:0]   i_key_time,
    input  logic [KEY_W-1:0]   i_position,
    output logic               o_valid,
    output logic [ADDR_W-1:0]  o_segment,
    output logic [KEY_W-1:0]   o_fraction,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    kfsl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kfsl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_cfg    (w_cfg),
        .i_sts    (w_sts),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    kfsl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_key_index (i_key_index),
        .i_key_time  (i_key_time),
        .i_position  (i_position),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_segment   (o_segment),
        .o_fraction  (o_fraction)
    );

endmodule

@@ rtl/kfsl_checker.sv @@
// Port-level checker for the keyframe segment locator, bound to the top level.
`timescale 1ns / 1ps
module kfsl_checker import kfsl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_busy,
    input logic              i_action,
    input logic              i_valid,
    input logic [ADDR_W-1:0] i_segment
);

    a_beat_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $past(i_busy))
        else $error("result beat without a query in progress");

    a_beat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid)
        else $error("result beats back to back");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("result beat while still busy");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && !i_action) |=> !i_busy)
        else $error("key write left the block busy");

    a_segment_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_segment != {ADDR_W{1'b1}}))
        else $error("segment index out of range");

endmodule

bind keyframe_segment_locator kfsl_checker u_kfsl_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (start),
    .i_busy    (busy),
    .i_action  (i_action),
    .i_valid   (o_valid),
    .i_segment (o_segment)
);

@@ sim/kfsl_test_pkg.sv @@
// Action codes of the locator command beat, shared by the testbench files.
`timescale 1ns / 1ps
package kfsl_test_pkg;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOCATE = 1'b1;

endpackage

@@ sim/keyframe_segment_locator_checker.sv @@
// Checker for the keyframe segment locator: mirrors its state and checks every result beat.
`timescale 1ns / 1ps
module keyframe_segment_locator_checker import kfsl_pkg::*, kfsl_test_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_key_index,
    input  logic [KEY_W-1:0]   i_key_time,
    input  logic [KEY_W-1:0]   i_position,
    input  logic               o_valid,
    input  logic [ADDR_W-1:0]  o_segment,
    input  logic [KEY_W-1:0]   o_fraction,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    typedef struct packed {
        logic [ADDR_W-1:0] segment;
        logic [KEY_W-1:0]  fraction;
    } t_located;

    logic [KEY_W-1:0] key_table [KEYS_MAX];
    t_cfg             cfg;
    int               resume_idx;
    t_located         awaited_spans [$];

    function automatic int active_count();
        int n;
        n = int'(cfg.num_keys);
        if (n < 2) n = 2;
        if (n > KEYS_MAX) n = KEYS_MAX;
        return n;
    endfunction

    function automatic int first_above(int from, int to, int thr);
        int i;
        i = from;
        while (i < to && int'(key_table[i]) <= thr) i++;
        return i;
    endfunction

    function automatic t_located locate_position(logic [KEY_W-1:0] pos);
        t_located res;
        int       n, thr, origin, idx, num, den, frac;
        longint   prod, quo;
        n = active_count();
        if (cfg.uniform_mode) begin
            prod = longint'(pos) * longint'(n - 1);
            if ((prod >> 16) >= longint'(n - 1)) begin
                res.segment  = ADDR_W'(n - 2);
                res.fraction = ONE_Q16;
            end else begin
                res.segment  = ADDR_W'(prod >> 16);
                res.fraction = {1'b0, prod[15:0]};
            end
            return res;
        end
        thr    = int'(pos) + int'(cfg.epsilon);
        origin = (resume_idx < n) ? resume_idx : n;
        idx    = first_above(origin, n, thr);
        if (idx > 0 && int'(key_table[idx - 1]) > thr) idx = first_above(0, origin, thr);
        if (idx == 0) idx = 1;
        resume_idx = idx;
        if (idx >= n) begin
            res.segment = ADDR_W'(n - 2);
            frac = int'(FRAC_LO);
        end else begin
            num = int'(key_table[idx]) - int'(pos);
            den = int'(key_table[idx]) - int'(key_table[idx - 1]);
            if (den == 0) begin
                frac = int'(FRAC_HI);
            end else if ((num < 0) != (den < 0) && num != 0) begin
                frac = int'(FRAC_LO);
            end else begin
                quo = (longint'(num < 0 ? -num : num) << 16) / longint'(den < 0 ? -den : den);
                if (quo < longint'(cfg.epsilon)) frac = int'(FRAC_LO);
                else if (quo > longint'(int'(ONE_Q16) - int'(cfg.epsilon))) frac = int'(FRAC_HI);
                else frac = int'(quo);
            end
            res.segment = ADDR_W'(idx - 1);
        end
        res.fraction = KEY_W'(int'(ONE_Q16) - frac);
        return res;
    endfunction

    task automatic note_mismatch(bit orphan, t_located want, t_located got);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            if (orphan)
                $display("%0t: result beat segment %0d fraction %0d with no locate pending",
                         $time, got.segment, got.fraction);
            else
                $display("%0t: mismatch segment exp %0d got %0d, fraction exp %0d got %0d",
                         $time, want.segment, got.segment, want.fraction, got.fraction);
        end
    endtask

    always @(posedge i_clk) begin : check_edge
        t_located got, want;
        if (!i_rst_n) begin
            cfg        = '{num_keys: 9'd2, uniform_mode: 1'b1, epsilon: 13'd7};
            resume_idx = 0;
            awaited_spans.delete();
        end else begin
            if (o_valid) begin
                got = '{segment: o_segment, fraction: o_fraction};
                if (awaited_spans.size() == 0) begin
                    note_mismatch(1'b1, got, got);
                end else begin
                    want = awaited_spans.pop_front();
                    if (got.segment !== want.segment || got.fraction !== want.fraction)
                        note_mismatch(1'b0, want, got);
                end
            end
            if (start && !busy) begin
                if (i_action == ACT_WRITE) key_table[i_key_index] = i_key_time;
                else awaited_spans.push_back(locate_position(i_position));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    {REG_NUM_KEYS, 2'b00}: cfg.num_keys     = pwdata[IDX_W-1:0];
                    {REG_UNIFORM, 2'b00}:  cfg.uniform_mode = pwdata[0];
                    {REG_EPSILON, 2'b00}:  cfg.epsilon      = pwdata[EPS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = awaited_spans.size();
    end

endmodule

@@ sim/keyframe_segment_locator_test.sv @@
// Testbench top for the keyframe segment locator: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module keyframe_segment_locator_test;
    import kfsl_pkg::*;
    import kfsl_test_pkg::*;

    localparam int RANDOM_BEATS = 560;
    localparam int STALL_LIMIT  = 20000;
    localparam int PAUSE_CYCLES = 8;
    localparam int TAIL_CYCLES  = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_action;
    logic [ADDR_W-1:0]  i_key_index;
    logic [KEY_W-1:0]   i_key_time;
    logic [KEY_W-1:0]   i_position;
    logic               o_valid;
    logic [ADDR_W-1:0]  o_segment;
    logic [KEY_W-1:0]   o_fraction;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatches;
    int outstanding;
    int sender_idle_pct;
    int beats_sent;

    keyframe_segment_locator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_key_index (i_key_index),
        .i_key_time  (i_key_time),
        .i_position  (i_position),
        .o_valid     (o_valid),
        .o_segment   (o_segment),
        .o_fraction  (o_fraction),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    keyframe_segment_locator_checker locate_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key_index   (i_key_index),
        .i_key_time    (i_key_time),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_segment     (o_segment),
        .o_fraction    (o_fraction),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pwrite)) quiet = 0;
            else quiet++;
        end
        $display("keyframe_segment_locator_test failed");
        $finish;
    end

    task automatic drive_beat(input logic act, input logic [ADDR_W-1:0] kidx,
                              input logic [KEY_W-1:0] ktime, input logic [KEY_W-1:0] pos);
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start       = 1'b1;
        i_action    = act;
        i_key_index = kidx;
        i_key_time  = ktime;
        i_position  = pos;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic write_key(input int kidx, input int ktime);
        drive_beat(ACT_WRITE, ADDR_W'(kidx), KEY_W'(ktime), KEY_W'($urandom));
    endtask

    task automatic locate(input int pos);
        drive_beat(ACT_LOCATE, ADDR_W'($urandom), KEY_W'($urandom), KEY_W'(pos));
    endtask

    task automatic settle();
        start = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (PAUSE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input int keys, input int uniform, input int eps);
        settle();
        apb_write(REG_NUM_KEYS, keys);
        apb_write(REG_UNIFORM, uniform);
        apb_write(REG_EPSILON, eps);
    endtask

    task automatic load_ramp(input int span);
        int step, t, prev, i;
        step = 65536 / (span - 1);
        prev = 0;
        for (i = 0; i < span; i++) begin
            t = i * step + $urandom_range(0, step / 2);
            if (i > 0 && $urandom_range(99) < 3) t = prev;
            if (t > 65536) t = 65536;
            write_key(i, t);
            prev = t;
        end
    endtask

    task automatic run_segment();
        int pick, keys, span, uniform, eps, queries, cursor, kind, q;
        pick = $urandom_range(99);
        if (pick < 70) keys = $urandom_range(2, 12);
        else if (pick < 90) keys = $urandom_range(13, 64);
        else if (pick < 93) keys = KEYS_MAX;
        else if (pick < 97) keys = $urandom_range(0, 1);
        else keys = $urandom_range(KEYS_MAX + 1, 511);
        span    = (keys < 2) ? 2 : (keys > KEYS_MAX) ? KEYS_MAX : keys;
        uniform = ($urandom_range(99) < 35) ? 1 : 0;
        pick    = $urandom_range(99);
        if (pick < 10) eps = 0;
        else if (pick < 20) eps = 4096;
        else if (pick < 70) eps = $urandom_range(0, 64);
        else eps = $urandom_range(0, 4096);
        set_config(keys, uniform, eps);
        if (uniform == 0 && $urandom_range(99) < 65) load_ramp(span);
        queries = $urandom_range(8, 30);
        cursor  = $urandom_range(0, 30000);
        for (q = 0; q < queries; q++) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                drive_beat(ACT_WRITE, ADDR_W'($urandom), KEY_W'($urandom_range(0, 131071)),
                           KEY_W'($urandom));
            end else if (kind < 65) begin
                cursor += $urandom_range(0, 131072 / span);
                if (cursor > 70000) cursor = $urandom_range(0, 3000);
                locate(cursor);
            end else if (kind < 90) begin
                locate($urandom_range(0, 65536));
            end else begin
                locate($urandom_range(0, 131071));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_action        = ACT_WRITE;
        i_key_index     = '0;
        i_key_time      = '0;
        i_position      = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sender_idle_pct = 0;
        beats_sent      = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        load_ramp(KEYS_MAX);

        locate(0);
        locate(65535);
        locate(65536);
        locate(131071);
        set_config(0, 1, 7);
        locate(32768);
        set_config(511, 1, 0);
        locate(1);
        locate(98304);
        set_config(4, 0, 7);
        write_key(0, 1000);
        write_key(1, 20000);
        write_key(2, 40000);
        write_key(3, 60000);
        locate(30000);
        locate(10000);
        locate(0);
        locate(19995);
        locate(62000);
        set_config(4, 0, 4096);
        locate(20500);
        // zero-length segment, keys out of order, quotient above one
        set_config(2, 0, 7);
        write_key(0, 50000);
        write_key(1, 50000);
        locate(0);
        write_key(0, 60000);
        write_key(1, 50000);
        locate(100);
        write_key(0, 40000);
        write_key(1, 50000);
        locate(0);
        write_key(255, 131071);

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent < RANDOM_BEATS / 3) sender_idle_pct = 31;
            else if (beats_sent < 2 * RANDOM_BEATS / 3) sender_idle_pct = 81;
            else sender_idle_pct = 0;
            run_segment();
        end

        start = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("keyframe_segment_locator_test passed");
        end else begin
            $display("keyframe_segment_locator_test failed");
        end
        $finish;
    end

endmodule
